/* hdl/sam_pkg.sv */
// Shared types and constants for the slotted ALOHA MAC core.
package sam_pkg;

  localparam int unsigned FieldW    = 16;
  localparam int unsigned RetryW    = 8;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CntW      = 2;
  localparam int unsigned MaxShift  = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_OWN_ADDRESS    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SEND_TIMEOUT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FRAME_TX_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SLOT_SHIFT     = 3'd4;

  // Configuration reset values
  localparam logic [FieldW-1:0] RST_OWN_ADDRESS    = 16'd0;
  localparam logic [RetryW-1:0] RST_RETRY_LIMIT    = 8'd3;
  localparam logic [FieldW-1:0] RST_SEND_TIMEOUT   = 16'd32;
  localparam logic [FieldW-1:0] RST_FRAME_TX_TICKS = 16'd16;
  localparam logic [ShiftW-1:0] RST_SLOT_SHIFT     = 5'd4;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_REQ   = 2'd1,
    KIND_FRAME = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [FieldW-1:0] own_address;
    logic [RetryW-1:0] retry_limit;
    logic [FieldW-1:0] send_timeout;
    logic [FieldW-1:0] frame_tx_ticks;
    logic [ShiftW-1:0] slot_shift;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [FieldW-1:0] frame_src;
    logic [FieldW-1:0] frame_dst;
    logic [FieldW-1:0] frame_duration;
    logic [FieldW-1:0] backoff_ticks;
  } item_t;

  typedef struct packed {
    logic              transmit_start;
    logic              tx_success;
    logic              tx_given_up;
    logic              deliver_up;
    logic [FieldW-1:0] deliver_src;
    logic [FieldW-1:0] deliver_dst;
    logic              collision;
    logic [CntW-1:0]   collisions_for_us;
    logic              request_refused;
  } result_t;

endpackage

/* hdl/sam_cfg_regs.sv */
// Configuration register file of the slotted ALOHA MAC core.
module sam_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sam_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sam_pkg::FieldW-1:0]     cfg_wdata_i,
  output sam_pkg::cfg_t                  cfg_o
);

  sam_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sam_pkg::REG_OWN_ADDRESS:    cfg_d.own_address    = cfg_wdata_i;
        sam_pkg::REG_RETRY_LIMIT:    cfg_d.retry_limit    = cfg_wdata_i[sam_pkg::RetryW-1:0];
        sam_pkg::REG_SEND_TIMEOUT:   cfg_d.send_timeout   = cfg_wdata_i;
        sam_pkg::REG_FRAME_TX_TICKS: cfg_d.frame_tx_ticks = cfg_wdata_i;
        sam_pkg::REG_SLOT_SHIFT:     cfg_d.slot_shift     = cfg_wdata_i[sam_pkg::ShiftW-1:0];
        default:                     cfg_d = cfg_q; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address    <= sam_pkg::RST_OWN_ADDRESS;
      cfg_q.retry_limit    <= sam_pkg::RST_RETRY_LIMIT;
      cfg_q.send_timeout   <= sam_pkg::RST_SEND_TIMEOUT;
      cfg_q.frame_tx_ticks <= sam_pkg::RST_FRAME_TX_TICKS;
      cfg_q.slot_shift     <= sam_pkg::RST_SLOT_SHIFT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sam_engine.sv */
// MAC state and the single-pass next-state and result logic for one request.
module sam_engine #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sam_pkg::item_t    item_i,
  input  sam_pkg::cfg_t     cfg_i,
  output sam_pkg::result_t  res_o
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned FW = sam_pkg::FieldW;
  localparam int unsigned AW = (ADDR_BITS < FW) ? ADDR_BITS : FW;
  // Broadcast can only match when the whole address mask fits in a field
  localparam bit BcastOk = (ADDR_BITS <= FW);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_SEND    = 2'd1,
    MODE_BACKOFF = 2'd2
  } tx_mode_e;

  logic [TW-1:0]                 tick_q, tick_d;
  tx_mode_e                      mode_q, mode_d;
  logic [sam_pkg::RetryW-1:0]    retry_q, retry_d;
  logic [TW-1:0]                 deadline_q, deadline_d;
  logic                          rx_busy_q, rx_busy_d;
  logic [TW-1:0]                 cend_q, cend_d;
  logic                          pend_q, pend_d;
  logic [FW-1:0]                 psrc_q, psrc_d;
  logic [FW-1:0]                 pdst_q, pdst_d;

  function automatic logic for_us(input logic [FW-1:0] dst, input logic [FW-1:0] own);
    logic bc;
    bc = BcastOk && (dst[AW-1:0] == {AW{1'b1}});
    return bc || (dst[AW-1:0] == own[AW-1:0]);
  endfunction

  // Reached when now - t lies in the lower half of the time circle
  function automatic logic reached(input logic [TW-1:0] now, input logic [TW-1:0] t);
    logic [TW-1:0] diff;
    diff = now - t;
    return !diff[TW-1];
  endfunction

  logic [sam_pkg::ShiftW-1:0] shift_c;
  logic [TW-1:0]              slot_mask;
  logic [TW-1:0]              tick_inc;
  logic [TW-1:0]              frame_end;
  logic [TW-1:0]              end_diff;
  logic [TW-1:0]              send_base_tick;
  logic [TW-1:0]              send_base_req;
  logic [TW-1:0]              bo_base;
  logic [sam_pkg::RetryW:0]   retry_nx;
  tx_mode_e                   mode_a;
  logic [sam_pkg::RetryW-1:0] retry_a;
  logic                       n_old;
  logic                       n_new;

  assign shift_c   = (cfg_i.slot_shift > sam_pkg::ShiftW'(sam_pkg::MaxShift))
                     ? sam_pkg::ShiftW'(sam_pkg::MaxShift) : cfg_i.slot_shift;
  assign slot_mask = (TW'(1) << shift_c) - TW'(1);
  assign tick_inc  = tick_q + TW'(1);
  assign frame_end = tick_q + TW'(item_i.frame_duration);
  assign end_diff  = frame_end - cend_q;
  assign send_base_tick = tick_inc + TW'(cfg_i.send_timeout) + TW'(cfg_i.frame_tx_ticks);
  assign send_base_req  = tick_q + TW'(cfg_i.send_timeout) + TW'(cfg_i.frame_tx_ticks);
  assign bo_base   = tick_inc + TW'(item_i.backoff_ticks);

  always_comb begin
    tick_d     = tick_q;
    mode_d     = mode_q;
    retry_d    = retry_q;
    deadline_d = deadline_q;
    rx_busy_d  = rx_busy_q;
    cend_d     = cend_q;
    pend_d     = pend_q;
    psrc_d     = psrc_q;
    pdst_d     = pdst_q;
    res_o      = '0;
    mode_a     = mode_q;
    retry_a    = retry_q;
    retry_nx   = '0;
    n_old      = 1'b0;
    n_new      = 1'b0;

    unique case (item_i.kind)
      sam_pkg::KIND_TICK: begin
        tick_d = tick_inc;
        // Close the contention window first so an echo beats a timeout
        if (rx_busy_q && reached(tick_inc, cend_q)) begin
          rx_busy_d = 1'b0;
          if (pend_q) begin
            pend_d = 1'b0;
            if (psrc_q[AW-1:0] == cfg_i.own_address[AW-1:0]) begin
              res_o.tx_success = 1'b1;
              mode_a  = MODE_IDLE;
              retry_a = '0;
            end else if (for_us(pdst_q, cfg_i.own_address)) begin
              res_o.deliver_up  = 1'b1;
              res_o.deliver_src = psrc_q;
              res_o.deliver_dst = pdst_q;
            end
          end
        end
        mode_d  = mode_a;
        retry_d = retry_a;
        if ((mode_a == MODE_SEND || mode_a == MODE_BACKOFF)
            && reached(tick_inc, deadline_q)) begin
          if (mode_a == MODE_SEND) begin
            retry_nx = {1'b0, retry_a} + (sam_pkg::RetryW+1)'(1);
            if (retry_nx <= {1'b0, cfg_i.retry_limit}) begin
              retry_d    = retry_nx[sam_pkg::RetryW-1:0];
              mode_d     = MODE_BACKOFF;
              deadline_d = (bo_base | slot_mask) + TW'(1);
            end else begin
              res_o.tx_given_up = 1'b1;
              mode_d  = MODE_IDLE;
              retry_d = '0;
            end
          end else begin
            res_o.transmit_start = 1'b1;
            mode_d     = MODE_SEND;
            deadline_d = (send_base_tick | slot_mask) + TW'(1);
          end
        end
      end
      sam_pkg::KIND_REQ: begin
        if (mode_q == MODE_IDLE) begin
          res_o.transmit_start = 1'b1;
          mode_d     = MODE_SEND;
          deadline_d = (send_base_req | slot_mask) + TW'(1);
        end else begin
          res_o.request_refused = 1'b1;
        end
      end
      sam_pkg::KIND_FRAME: begin
        if (!rx_busy_q) begin
          rx_busy_d = 1'b1;
          pend_d    = 1'b1;
          psrc_d    = item_i.frame_src;
          pdst_d    = item_i.frame_dst;
          cend_d    = frame_end;
        end else begin
          // Keep the window end as a running maximum
          if (end_diff != '0 && !end_diff[TW-1]) cend_d = frame_end;
          n_old  = pend_q && for_us(pdst_q, cfg_i.own_address);
          n_new  = for_us(item_i.frame_dst, cfg_i.own_address);
          pend_d = 1'b0;
          res_o.collision         = 1'b1;
          res_o.collisions_for_us = {1'b0, n_old} + {1'b0, n_new};
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      mode_q     <= MODE_IDLE;
      retry_q    <= '0;
      deadline_q <= '0;
      rx_busy_q  <= 1'b0;
      cend_q     <= '0;
      pend_q     <= 1'b0;
      psrc_q     <= '0;
      pdst_q     <= '0;
    end else if (step_i) begin
      tick_q     <= tick_d;
      mode_q     <= mode_d;
      retry_q    <= retry_d;
      deadline_q <= deadline_d;
      rx_busy_q  <= rx_busy_d;
      cend_q     <= cend_d;
      pend_q     <= pend_d;
      psrc_q     <= psrc_d;
      pdst_q     <= pdst_d;
    end
  end

  a_success_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.tx_success |-> !res_o.tx_given_up && !res_o.deliver_up)
    else $error("success reported together with give-up or delivery");

  a_start_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.transmit_start |=> mode_q == MODE_SEND)
    else $error("transmit start did not enter send mode");

  a_giveup_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.tx_given_up |=> mode_q == MODE_IDLE && retry_q == '0)
    else $error("give-up did not return transmit side to idle");

  a_coll_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.collision |=> rx_busy_q && !pend_q)
    else $error("collision left receive side in wrong state");

endmodule

/* hdl/slotted_aloha_mac_core.sv */
// Top level of the slotted ALOHA MAC core: request and result registers around the engine.
//
// Slotted ALOHA medium-access controller driven by a stream of requests: a tick
// (advances the station clock and fires the contention and send timers), a
// transmit request from the queue, or a frame start heard on the channel. Every
// request yields exactly one result. A request is taken into an input register,
// and once the result register is free or being emptied, the engine evaluates it
// against the MAC state in one combinational pass, updates it and loads the result
// register. A new request can be taken every cycle while the result side does
// not stall; the throughput of one request per cycle is set by that single state
// update per request. The input register keeps accepting while a finished result
// waits at the output, and stalls only when both registers are full. The
// configuration registers (own address, retry limit, send timeout, frame transmit
// time, slot shift) are written through a plain write port and take effect from
// the next cycle; write them only while no request is in flight. Times wrap modulo
// 2^TIME_BITS, addresses are compared on their low min(ADDR_BITS, FieldW) bits.
module slotted_aloha_mac_core #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sam_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sam_pkg::FieldW-1:0]      cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic [sam_pkg::FieldW-1:0]      frame_src_i,
  input  logic [sam_pkg::FieldW-1:0]      frame_dst_i,
  input  logic [sam_pkg::FieldW-1:0]      frame_duration_i,
  input  logic [sam_pkg::FieldW-1:0]      backoff_ticks_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            transmit_start_o,
  output logic                            tx_success_o,
  output logic                            tx_given_up_o,
  output logic                            deliver_up_o,
  output logic [sam_pkg::FieldW-1:0]      deliver_src_o,
  output logic [sam_pkg::FieldW-1:0]      deliver_dst_o,
  output logic                            collision_o,
  output logic [sam_pkg::CntW-1:0]        collisions_for_us_o,
  output logic                            request_refused_o
);

  sam_pkg::cfg_t    cfg;
  sam_pkg::item_t   item_q, item_d;
  sam_pkg::result_t res_c, res_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             in_take;

  sam_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the held request whenever the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    item_d.kind           = sam_pkg::kind_e'(kind_i);
    item_d.frame_src      = frame_src_i;
    item_d.frame_dst      = frame_dst_i;
    item_d.frame_duration = frame_duration_i;
    item_d.backoff_ticks  = backoff_ticks_i;
  end

  sam_engine #(
    .ADDR_BITS (ADDR_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_c)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on the handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_c;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign transmit_start_o    = res_q.transmit_start;
  assign tx_success_o        = res_q.tx_success;
  assign tx_given_up_o       = res_q.tx_given_up;
  assign deliver_up_o        = res_q.deliver_up;
  assign deliver_src_o       = res_q.deliver_src;
  assign deliver_dst_o       = res_q.deliver_dst;
  assign collision_o         = res_q.collision;
  assign collisions_for_us_o = res_q.collisions_for_us;
  assign request_refused_o   = res_q.request_refused;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("result overwritten while stalled");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request produced no result");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("request taken while both registers are full");

endmodule

/* sim/tb_slotted_aloha_mac_core.sv */
// Self-checking testbench for the slotted ALOHA MAC core: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb_slotted_aloha_mac_core;

  // Transmit side states of the predictor
  typedef enum logic [1:0] {
    TX_IDLE    = 2'd0,
    TX_SEND    = 2'd1,
    TX_BACKOFF = 2'd2,
    TX_UNUSED  = 2'd3
  } sender_e;

  // Shadow MAC: advances its own copy of the station state on every accepted
  // request and keeps the results still owed by the block, oldest first.
  class mac_scoreboard;
    sam_pkg::cfg_t    settings;
    logic [31:0]      now_ticks;
    sender_e          sender;
    logic [7:0]       retries;
    logic [31:0]      deadline;
    logic             rx_active;
    logic [31:0]      window_end;
    logic             held_valid;
    logic [15:0]      held_src;
    logic [15:0]      held_dst;
    sam_pkg::result_t awaited[$];
    int unsigned      failures;

    function new();
      settings = '{own_address: sam_pkg::RST_OWN_ADDRESS,
                   retry_limit: sam_pkg::RST_RETRY_LIMIT,
                   send_timeout: sam_pkg::RST_SEND_TIMEOUT,
                   frame_tx_ticks: sam_pkg::RST_FRAME_TX_TICKS,
                   slot_shift: sam_pkg::RST_SLOT_SHIFT};
      now_ticks  = '0;
      sender     = TX_IDLE;
      retries    = '0;
      deadline   = '0;
      rx_active  = 1'b0;
      window_end = '0;
      held_valid = 1'b0;
      held_src   = '0;
      held_dst   = '0;
      failures   = 0;
    endfunction

    function void set_register(logic [sam_pkg::CfgIdxW-1:0] idx,
                               logic [sam_pkg::FieldW-1:0] v);
      case (idx)
        sam_pkg::REG_OWN_ADDRESS:    settings.own_address    = v;
        sam_pkg::REG_RETRY_LIMIT:    settings.retry_limit    = v[sam_pkg::RetryW-1:0];
        sam_pkg::REG_SEND_TIMEOUT:   settings.send_timeout   = v;
        sam_pkg::REG_FRAME_TX_TICKS: settings.frame_tx_ticks = v;
        sam_pkg::REG_SLOT_SHIFT:     settings.slot_shift     = v[sam_pkg::ShiftW-1:0];
        default: ;
      endcase
    endfunction

    // A time counts as reached once it lies less than half the range behind now
    function bit reached(logic [31:0] t);
      logic [31:0] d;
      d = now_ticks - t;
      return !d[31];
    endfunction

    function logic [31:0] align_slot(logic [31:0] t);
      int unsigned s;
      s = (settings.slot_shift > sam_pkg::MaxShift) ? sam_pkg::MaxShift
                                                    : settings.slot_shift;
      return ((t >> s) + 32'd1) << s;
    endfunction

    function bit for_us(logic [15:0] dst);
      return (dst == 16'hFFFF) || (dst == settings.own_address);
    endfunction

    function void launch();
      sender   = TX_SEND;
      deadline = align_slot(now_ticks + settings.send_timeout + settings.frame_tx_ticks);
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void note_request(sam_pkg::item_t it);
      sam_pkg::result_t r;
      logic [31:0]      fin;
      logic [31:0]      gap;
      logic [1:0]       n;
      r = '0;
      case (it.kind)
        sam_pkg::KIND_TICK: begin
          now_ticks = now_ticks + 32'd1;
          // contention window first, so an echo beats a timeout on the same tick
          if (rx_active && reached(window_end)) begin
            rx_active = 1'b0;
            if (held_valid) begin
              held_valid = 1'b0;
              if (held_src == settings.own_address) begin
                r.tx_success = 1'b1;
                sender       = TX_IDLE;
                retries      = '0;
              end else if (for_us(held_dst)) begin
                r.deliver_up  = 1'b1;
                r.deliver_src = held_src;
                r.deliver_dst = held_dst;
              end
            end
          end
          if ((sender == TX_SEND || sender == TX_BACKOFF) && reached(deadline)) begin
            if (sender == TX_SEND) begin
              if (int'(retries) + 1 <= int'(settings.retry_limit)) begin
                retries  = retries + 8'd1;
                sender   = TX_BACKOFF;
                deadline = align_slot(now_ticks + {16'd0, it.backoff_ticks});
              end else begin
                r.tx_given_up = 1'b1;
                sender        = TX_IDLE;
                retries       = '0;
              end
            end else begin
              r.transmit_start = 1'b1;
              launch();
            end
          end
        end
        sam_pkg::KIND_REQ: begin
          if (sender == TX_IDLE) begin
            r.transmit_start = 1'b1;
            launch();
          end else begin
            r.request_refused = 1'b1;
          end
        end
        sam_pkg::KIND_FRAME: begin
          fin = now_ticks + {16'd0, it.frame_duration};
          if (!rx_active) begin
            rx_active  = 1'b1;
            held_valid = 1'b1;
            held_src   = it.frame_src;
            held_dst   = it.frame_dst;
            window_end = fin;
          end else begin
            // keep the window end as a running maximum
            gap = fin - window_end;
            if (gap != 32'd0 && !gap[31]) window_end = fin;
            n = 2'd0;
            if (held_valid && for_us(held_dst)) n = n + 2'd1;
            held_valid = 1'b0;
            if (for_us(it.frame_dst)) n = n + 2'd1;
            r.collision         = 1'b1;
            r.collisions_for_us = n;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
        failures++;
      end
    endfunction

    function void check_result(sam_pkg::result_t got);
      sam_pkg::result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        failures++;
        return;
      end
      e = awaited.pop_front();
      compare("transmit_start", e.transmit_start, got.transmit_start);
      compare("tx_success", e.tx_success, got.tx_success);
      compare("tx_given_up", e.tx_given_up, got.tx_given_up);
      compare("deliver_up", e.deliver_up, got.deliver_up);
      compare("deliver_src", e.deliver_src, got.deliver_src);
      compare("deliver_dst", e.deliver_dst, got.deliver_dst);
      compare("collision", e.collision, got.collision);
      compare("collisions_for_us", e.collisions_for_us, got.collisions_for_us);
      compare("request_refused", e.request_refused, got.request_refused);
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [sam_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [sam_pkg::FieldW-1:0]  cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [1:0]                  kind_i;
  logic [sam_pkg::FieldW-1:0]  frame_src_i;
  logic [sam_pkg::FieldW-1:0]  frame_dst_i;
  logic [sam_pkg::FieldW-1:0]  frame_duration_i;
  logic [sam_pkg::FieldW-1:0]  backoff_ticks_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        transmit_start_o;
  logic                        tx_success_o;
  logic                        tx_given_up_o;
  logic                        deliver_up_o;
  logic [sam_pkg::FieldW-1:0]  deliver_src_o;
  logic [sam_pkg::FieldW-1:0]  deliver_dst_o;
  logic                        collision_o;
  logic [sam_pkg::CntW-1:0]    collisions_for_us_o;
  logic                        request_refused_o;

  mac_scoreboard sb;
  // calm: no idling on either side while set
  bit            calm;
  int unsigned   sent;

  slotted_aloha_mac_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .frame_src_i         (frame_src_i),
    .frame_dst_i         (frame_dst_i),
    .frame_duration_i    (frame_duration_i),
    .backoff_ticks_i     (backoff_ticks_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .transmit_start_o    (transmit_start_o),
    .tx_success_o        (tx_success_o),
    .tx_given_up_o       (tx_given_up_o),
    .deliver_up_o        (deliver_up_o),
    .deliver_src_o       (deliver_src_o),
    .deliver_dst_o       (deliver_dst_o),
    .collision_o         (collision_o),
    .collisions_for_us_o (collisions_for_us_o),
    .request_refused_o   (request_refused_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Give up well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("** slotted_aloha_mac_core: FAILED **");
    $finish;
  end

  function automatic sam_pkg::item_t mk(sam_pkg::kind_e k, logic [15:0] src,
                                        logic [15:0] dst, logic [15:0] dur,
                                        logic [15:0] bo);
    sam_pkg::item_t it;
    it.kind           = k;
    it.frame_src      = src;
    it.frame_dst      = dst;
    it.frame_duration = dur;
    it.backoff_ticks  = bo;
    return it;
  endfunction

  // Tick with random don't-care payload; backoff draw mostly short
  function automatic sam_pkg::item_t rand_tick();
    logic [15:0] bo;
    bo = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    return mk(sam_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), bo);
  endfunction

  // One random request: ticks dominate, frames often carry our address
  function automatic sam_pkg::item_t random_request(logic [15:0] own);
    sam_pkg::item_t it;
    int unsigned    p;
    int unsigned    q;
    it = rand_tick();
    it.frame_duration = 16'($urandom_range(1, 24));
    if ($urandom_range(199) == 0) it.frame_duration = 16'($urandom_range(1, 65535));
    p = $urandom_range(99);
    if (p < 52) begin
      it.kind = sam_pkg::KIND_TICK;
    end else if (p < 66) begin
      it.kind = sam_pkg::KIND_REQ;
    end else if (p < 95) begin
      it.kind = sam_pkg::KIND_FRAME;
      q = $urandom_range(9);
      if (q < 4) it.frame_src = own;
      else if (q < 5) it.frame_src = own ^ (16'd1 << $urandom_range(15));
      q = $urandom_range(9);
      if (q < 3) it.frame_dst = own;
      else if (q < 5) it.frame_dst = 16'hFFFF;
    end else begin
      it.kind = sam_pkg::KIND_RSVD;
    end
    return it;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic drive_request(sam_pkg::item_t it);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= it.kind;
    frame_src_i      <= it.frame_src;
    frame_dst_i      <= it.frame_dst;
    frame_duration_i <= it.frame_duration;
    backoff_ticks_i  <= it.backoff_ticks;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(it);
    sent++;
  endtask

  // Drop valid and hold until every owed result has come, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all five registers on consecutive edges; only called while idle
  task automatic apply_settings(sam_pkg::cfg_t c);
    logic [sam_pkg::CfgIdxW-1:0] idx[5];
    logic [sam_pkg::FieldW-1:0]  val[5];
    idx = '{sam_pkg::REG_OWN_ADDRESS, sam_pkg::REG_RETRY_LIMIT, sam_pkg::REG_SEND_TIMEOUT,
            sam_pkg::REG_FRAME_TX_TICKS, sam_pkg::REG_SLOT_SHIFT};
    val = '{c.own_address, 16'(c.retry_limit), c.send_timeout, c.frame_tx_ticks,
            16'(c.slot_shift)};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
      sb.set_register(idx[i], val[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Well-formed exchange: request, a few ticks, our own echo, ticks to close the window
  task automatic exchange();
    int unsigned    k;
    logic [15:0]    d;
    sam_pkg::item_t it;
    drive_request(mk(sam_pkg::KIND_REQ, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom)));
    k = $urandom_range(0, 6);
    repeat (k) drive_request(rand_tick());
    d  = 16'($urandom_range(1, 8));
    it = mk(sam_pkg::KIND_FRAME, sb.settings.own_address, 16'($urandom), d,
            16'($urandom));
    if ($urandom_range(3) == 0) it.frame_dst = 16'hFFFF;
    drive_request(it);
    repeat (d + 1) drive_request(rand_tick());
  endtask

  // Result side: check every accepted result, stall at random unless calm
  initial begin
    sam_pkg::result_t got;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.transmit_start    = transmit_start_o;
        got.tx_success        = tx_success_o;
        got.tx_given_up       = tx_given_up_o;
        got.deliver_up        = deliver_up_o;
        got.deliver_src       = deliver_src_o;
        got.deliver_dst       = deliver_dst_o;
        got.collision         = collision_o;
        got.collisions_for_us = collisions_for_us_o;
        got.request_refused   = request_refused_o;
        sb.check_result(got);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 37);
    end
  end

  // Main sequence: reset, directed requests, then one random phase per setting
  initial begin
    sam_pkg::cfg_t phases[6];
    int unsigned   target;
    sb   = new();
    calm = 1'b0;
    sent = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= '0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    kind_i           <= '0;
    frame_src_i      <= '0;
    frame_dst_i      <= '0;
    frame_duration_i <= '0;
    backoff_ticks_i  <= '0;

    // Reset values first, then corners: zero timers, broadcast own address,
    // unreachable deadlines and a slot shift beyond the clamp
    phases[0] = '{own_address: 16'h0000, retry_limit: 8'd3, send_timeout: 16'd32,
                  frame_tx_ticks: 16'd16, slot_shift: 5'd4};
    phases[1] = '{own_address: 16'h1234, retry_limit: 8'd0, send_timeout: 16'd0,
                  frame_tx_ticks: 16'd1, slot_shift: 5'd0};
    phases[2] = '{own_address: 16'hFFFF, retry_limit: 8'd255, send_timeout: 16'd3,
                  frame_tx_ticks: 16'd2, slot_shift: 5'd1};
    phases[3] = '{own_address: 16'h0000, retry_limit: 8'd2, send_timeout: 16'd5,
                  frame_tx_ticks: 16'd4, slot_shift: 5'd16};
    phases[4] = '{own_address: 16'hA5C3, retry_limit: 8'd1, send_timeout: 16'd65535,
                  frame_tx_ticks: 16'd65535, slot_shift: 5'd31};
    phases[5] = '{own_address: 16'h5A3C, retry_limit: 8'd4, send_timeout: 16'd6,
                  frame_tx_ticks: 16'd3, slot_shift: 5'd2};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset settings, own address zero
    drive_request(mk(sam_pkg::KIND_RSVD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drive_request(mk(sam_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drive_request(mk(sam_pkg::KIND_REQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drive_request(mk(sam_pkg::KIND_REQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // zero-length echo closes on the very next tick
    drive_request(mk(sam_pkg::KIND_FRAME, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    drive_request(mk(sam_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // two frames for us collide
    drive_request(mk(sam_pkg::KIND_FRAME, 16'h1111, 16'h0000, 16'd3, 16'h0000));
    drive_request(mk(sam_pkg::KIND_FRAME, 16'h2222, 16'hFFFF, 16'd1, 16'h0000));
    repeat (4) drive_request(rand_tick());
    // clean delivery
    drive_request(mk(sam_pkg::KIND_FRAME, 16'h3333, 16'h0000, 16'd1, 16'h0000));
    repeat (2) drive_request(rand_tick());
    // frame for someone else is ignored
    drive_request(mk(sam_pkg::KIND_FRAME, 16'h4444, 16'h5555, 16'd1, 16'h0000));
    repeat (2) drive_request(rand_tick());
    drive_request(mk(sam_pkg::KIND_REQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      apply_settings(phases[ph]);
      @(posedge clk_i);
      // last phase runs without any idling
      calm   = (ph == 5);
      target = sent + 150;
      while (sent < target) begin
        if ($urandom_range(99) < 25) exchange();
        else drive_request(random_request(sb.settings.own_address));
        // hold the sender after each request while sent lies 75 to 71 short of the target, until every result is in
        if (ph == 2 && sent >= target - 75 && sent < target - 70) settle();
      end
    end

    // Longest frame, then frames colliding with it; the window end must not move back
    calm = 1'b0;
    drive_request(mk(sam_pkg::KIND_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
    drive_request(mk(sam_pkg::KIND_FRAME, 16'h0000, 16'h7777, 16'd1, 16'h0000));
    drive_request(mk(sam_pkg::KIND_FRAME, sb.settings.own_address,
                     sb.settings.own_address, 16'd2, 16'h0000));
    repeat (2) drive_request(rand_tick());
    drive_request(mk(sam_pkg::KIND_RSVD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("** slotted_aloha_mac_core: PASSED **");
    end else begin
      $display("** slotted_aloha_mac_core: FAILED **");
    end
    $finish;
  end

endmodule
